// ===== hw/rtl/drle_pkg.sv =====
`default_nettype none

package drle_pkg;

    // Decimal digits held in the run count.
    localparam int COUNT_DIGITS = 5;
    localparam int POS_W = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;

    // Entries in the queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    localparam logic [3:0] DIGIT_MAX = 4'd9;
    localparam logic [5:0] CH_ZERO = 6'd48;
    localparam logic [5:0] CH_SPACE = 6'd32;

    typedef logic [3:0] bcd_digit_t;
    typedef bcd_digit_t [COUNT_DIGITS-1:0] bcd_count_t;
    typedef logic [POS_W-1:0] pos_t;

    // One queue entry: the group a digit change (or full count) closed, and
    // the group an end of string flushes. Either or both may be present.
    typedef struct packed {
        logic       a_valid;
        bcd_count_t a_count;
        bcd_digit_t a_digit;
        logic       a_space;
        logic       b_valid;
        bcd_count_t b_count;
        bcd_digit_t b_digit;
    } group_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [1:0] {
        BK_START,
        BK_COUNT,
        BK_DIGIT,
        BK_SPACE
    } back_state_t;

    function automatic logic bcd_at_max(input bcd_count_t cnt);
        logic all9;
        all9 = 1'b1;
        for (int k = 0; k < COUNT_DIGITS; k++) begin
            if (cnt[k] != DIGIT_MAX)
            begin
                all9 = 1'b0;
            end
        end
        return all9;
    endfunction

    function automatic bcd_count_t bcd_incr(input bcd_count_t cnt);
        bcd_count_t res;
        logic carry;
        res = cnt;
        carry = 1'b1;
        for (int k = 0; k < COUNT_DIGITS; k++) begin
            if (carry)
            begin
                if (cnt[k] < DIGIT_MAX)
                begin
                    res[k] = cnt[k] + 4'd1;
                    carry = 1'b0;
                end
                else
                begin
                    res[k] = 4'd0;
                end
            end
        end
        return res;
    endfunction

    // Position of the most significant nonzero digit, 0 if none.
    function automatic pos_t bcd_top(input bcd_count_t cnt);
        pos_t top;
        top = '0;
        for (int k = 0; k < COUNT_DIGITS; k++) begin
            if (cnt[k] != 4'd0)
            begin
                top = pos_t'(k);
            end
        end
        return top;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/drle_if.sv =====
`default_nettype none

interface drle_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] digit_value;
    logic       end_of_string;

    modport source (output valid, output digit_value, output end_of_string, input ready);
    modport sink (input valid, input digit_value, input end_of_string, output ready);
endinterface

interface drle_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] out_char;
    logic       last_of_item;
    logic       end_of_code;

    modport source (output valid, output out_char, output last_of_item, output end_of_code,
                    input ready);
    modport sink (input valid, input out_char, input last_of_item, input end_of_code,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/drle_queue.sv =====
`default_nettype none

module drle_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  drle_pkg::group_entry_t     push_data,
    input  wire logic                  pop,
    output drle_pkg::group_entry_t     head,
    output drle_pkg::queue_status_t    status
);

    drle_pkg::group_entry_t mem [drle_pkg::QUEUE_DEPTH];

    logic [drle_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [drle_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [drle_pkg::QCNT_W-1:0] count_reg, count_next;

    function automatic logic [drle_pkg::QPTR_W-1:0] ptr_inc(
        input logic [drle_pkg::QPTR_W-1:0] p);
        if (p == drle_pkg::QPTR_W'(drle_pkg::QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head = mem[rd_ptr_reg];
    assign status.full = (count_reg == drle_pkg::QCNT_W'(drle_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/drle_front.sv =====
`default_nettype none

module drle_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_wdata,
    drle_in_if.sink                 digit_ch,
    input  wire logic               queue_full,
    output logic                    push,
    output drle_pkg::group_entry_t  push_data
);

    logic                  emit_separator_reg;
    drle_pkg::bcd_digit_t  run_digit_reg, run_digit_next;
    drle_pkg::bcd_count_t  run_count_reg, run_count_next;
    logic                  run_open_reg, run_open_next;

    drle_pkg::bcd_digit_t  digit;
    drle_pkg::bcd_digit_t  new_digit;
    drle_pkg::bcd_count_t  new_count;
    logic                  accept;
    logic                  extend;

    assign digit_ch.ready = !queue_full;
    assign accept = digit_ch.valid && digit_ch.ready;

    always_comb
    begin
        // digits above nine count as nine
        digit = (digit_ch.digit_value > drle_pkg::DIGIT_MAX) ? drle_pkg::DIGIT_MAX
                                                              : digit_ch.digit_value;
        extend = run_open_reg && (digit == run_digit_reg)
                 && !drle_pkg::bcd_at_max(run_count_reg);
        new_digit = extend ? run_digit_reg : digit;
        new_count = extend ? drle_pkg::bcd_incr(run_count_reg)
                           : drle_pkg::bcd_count_t'(1);

        push_data.a_valid = run_open_reg && !extend;
        push_data.a_count = run_count_reg;
        push_data.a_digit = run_digit_reg;
        push_data.a_space = emit_separator_reg;
        push_data.b_valid = digit_ch.end_of_string;
        push_data.b_count = new_count;
        push_data.b_digit = new_digit;

        push = accept && (push_data.a_valid || push_data.b_valid);

        run_digit_next = run_digit_reg;
        run_count_next = run_count_reg;
        run_open_next = run_open_reg;
        if (accept)
        begin
            if (digit_ch.end_of_string)
            begin
                run_digit_next = '0;
                run_count_next = '0;
                run_open_next = 1'b0;
            end
            else
            begin
                run_digit_next = new_digit;
                run_count_next = new_count;
                run_open_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_separator_reg <= 1'b0;
            run_digit_reg <= '0;
            run_count_reg <= '0;
            run_open_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                emit_separator_reg <= cfg_wdata;
            end
            run_digit_reg <= run_digit_next;
            run_count_reg <= run_count_next;
            run_open_reg <= run_open_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/drle_back.sv =====
`default_nettype none

module drle_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  drle_pkg::group_entry_t  head,
    input  wire logic               queue_empty,
    output logic                    pop,
    drle_out_if.source              code_ch
);

    drle_pkg::back_state_t state_reg, state_next;
    logic                  grp_reg, grp_next;
    drle_pkg::pos_t        pos_reg, pos_next;

    logic                  out_valid_reg;
    logic [5:0]            out_char_reg;
    logic                  out_last_reg;
    logic                  out_eoc_reg;

    logic                  advance;
    logic                  emit;
    logic                  done;
    logic                  grp;
    logic [5:0]            ch;
    logic                  last;
    logic                  eoc;
    drle_pkg::bcd_count_t  cnt;
    drle_pkg::bcd_digit_t  dig;
    drle_pkg::pos_t        top;

    assign advance = !out_valid_reg || code_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        grp_next = grp_reg;
        pos_next = pos_reg;
        pop = 1'b0;
        emit = 1'b0;
        done = 1'b0;
        ch = drle_pkg::CH_ZERO;
        last = 1'b0;
        eoc = 1'b0;

        // entry without a closed group starts straight on the flush group
        grp = (state_reg == drle_pkg::BK_START) ? (grp_reg || !head.a_valid) : grp_reg;
        cnt = grp ? head.b_count : head.a_count;
        dig = grp ? head.b_digit : head.a_digit;
        top = drle_pkg::bcd_top(cnt);

        if (!queue_empty && advance)
        begin
            emit = 1'b1;
            grp_next = grp;
            unique case (state_reg)
                drle_pkg::BK_START:
                begin
                    ch = drle_pkg::CH_ZERO + {2'b00, cnt[top]};
                    if (top == '0)
                    begin
                        state_next = drle_pkg::BK_DIGIT;
                    end
                    else
                    begin
                        state_next = drle_pkg::BK_COUNT;
                        pos_next = top - 1'b1;
                    end
                end
                drle_pkg::BK_COUNT:
                begin
                    ch = drle_pkg::CH_ZERO + {2'b00, cnt[pos_reg]};
                    if (pos_reg == '0)
                    begin
                        state_next = drle_pkg::BK_DIGIT;
                    end
                    else
                    begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
                drle_pkg::BK_DIGIT:
                begin
                    ch = drle_pkg::CH_ZERO + {2'b00, dig};
                    if (!grp && head.a_space)
                    begin
                        state_next = drle_pkg::BK_SPACE;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
                drle_pkg::BK_SPACE:
                begin
                    ch = drle_pkg::CH_SPACE;
                    done = 1'b1;
                end
                default:
                begin
                    state_next = drle_pkg::BK_START;
                end
            endcase

            if (done)
            begin
                state_next = drle_pkg::BK_START;
                if (!grp && head.b_valid)
                begin
                    grp_next = 1'b1;
                end
                else
                begin
                    grp_next = 1'b0;
                    pop = 1'b1;
                    last = 1'b1;
                    eoc = grp;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= drle_pkg::BK_START;
            grp_reg <= 1'b0;
            pos_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            grp_reg <= grp_next;
            pos_reg <= pos_next;
            if (advance)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_char_reg <= ch;
            out_last_reg <= last;
            out_eoc_reg <= eoc;
        end
    end

    assign code_ch.valid = out_valid_reg;
    assign code_ch.out_char = out_char_reg;
    assign code_ch.last_of_item = out_last_reg;
    assign code_ch.end_of_code = out_eoc_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/digit_run_length_encoder.sv =====
// Run-length encoder for a stream of decimal digits. Each beat on digit_ch
// carries one digit (10..15 are taken as 9) and an end-of-string mark; each
// beat on code_ch is one ASCII character of the code: the run count in
// decimal without leading zeros, then the run digit, then a space after every
// group but the final one when the separator register is set. The count holds
// five BCD digits; a run that reaches 99999 closes and a new run of the same
// digit starts. last_of_item marks the final character caused by one input
// beat, end_of_code the last character of the string. Rate: the front takes
// one digit every cycle while its 4-entry group queue has room; the back
// sequencer writes one character per cycle through a registered output
// stage while the receiver keeps code_ch ready, so a closed group costs its
// count digits, the digit and, when set, a space as characters on code_ch,
// and that character rate sets the sustained throughput of strings with short
// runs. A closed group is registered in the queue, its characters in the
// output stage. Write cfg_we/cfg_wdata only while no string is in flight.

`default_nettype none

module digit_run_length_encoder (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_we,
    input  wire logic   cfg_wdata,
    drle_in_if.sink     digit_ch,
    drle_out_if.source  code_ch
);

    drle_pkg::group_entry_t  push_data;
    drle_pkg::group_entry_t  head;
    drle_pkg::queue_status_t q_status;
    logic                    push;
    logic                    pop;

    // front: run tracking, BCD count, group detection
    drle_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .digit_ch   (digit_ch),
        .queue_full (q_status.full),
        .push       (push),
        .push_data  (push_data)
    );

    // closed groups waiting to be spelled out
    drle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // back: one character per cycle per group while code_ch is ready
    drle_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .queue_empty (q_status.empty),
        .pop         (pop),
        .code_ch     (code_ch)
    );

endmodule

`default_nettype wire

// ===== dv/drle_code_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels, predicts the character code for every accepted
// digit beat and compares it with the code beats the block sends.
module drle_code_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    drle_in_if   digit_mon,
    drle_out_if  code_mon,
    output int   failures,
    output int   outstanding
);

    typedef struct packed {
        logic [5:0] ch;
        logic       item_end;
        logic       code_end;
    } code_beat_t;

    code_beat_t expected_code[$];

    // Encoder state as the block should hold it
    logic                 separator_on;
    logic                 run_active;
    drle_pkg::bcd_digit_t cur_digit;
    drle_pkg::bcd_count_t cur_count;

    // Characters caused by one digit beat (at most 9)
    logic [5:0] burst [0:8];
    int         burst_len;

    int mismatches;
    int code_beats;

    assign failures = mismatches + outstanding;

    task automatic add_char(input logic [5:0] ch);
        burst[burst_len] = ch;
        burst_len = burst_len + 1;
    endtask

    // Count without leading zeros, then the digit, then an optional space
    task automatic emit_group_chars(input logic with_space);
        int top_pos;
        top_pos = 0;
        for (int k = 0; k < drle_pkg::COUNT_DIGITS; k++)
        begin
            if (cur_count[k] != 4'd0)
            begin
                top_pos = k;
            end
        end
        for (int k = top_pos; k >= 0; k--)
        begin
            add_char(drle_pkg::CH_ZERO + 6'(cur_count[k]));
        end
        add_char(drle_pkg::CH_ZERO + 6'(cur_digit));
        if (with_space)
        begin
            add_char(drle_pkg::CH_SPACE);
        end
    endtask

    task automatic encode_digit(input logic [3:0] raw, input logic eos);
        drle_pkg::bcd_digit_t d;
        logic                 carry;
        burst_len = 0;
        d = (raw > drle_pkg::DIGIT_MAX) ? drle_pkg::DIGIT_MAX : raw;
        if (run_active && d == cur_digit
            && cur_count != {drle_pkg::COUNT_DIGITS{drle_pkg::DIGIT_MAX}})
        begin
            carry = 1'b1;
            for (int k = 0; k < drle_pkg::COUNT_DIGITS; k++)
            begin
                if (carry)
                begin
                    if (cur_count[k] == drle_pkg::DIGIT_MAX)
                    begin
                        cur_count[k] = 4'd0;
                    end
                    else
                    begin
                        cur_count[k] = cur_count[k] + 4'd1;
                        carry = 1'b0;
                    end
                end
            end
        end
        else
        begin
            // digit change or full count closes the open group
            if (run_active)
            begin
                emit_group_chars(separator_on);
            end
            cur_digit = d;
            cur_count = drle_pkg::bcd_count_t'(1);
            run_active = 1'b1;
        end
        if (eos)
        begin
            emit_group_chars(1'b0);
            run_active = 1'b0;
            cur_digit = '0;
            cur_count = '0;
        end
        for (int i = 0; i < burst_len; i++)
        begin
            expected_code.push_back({burst[i], i == burst_len - 1,
                                     eos && (i == burst_len - 1)});
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR: code beat %0d: %s is %0d, expected %0d",
                 code_beats, what, got, want);
        mismatches = mismatches + 1;
    endtask

    task automatic check_code_beat();
        code_beat_t want;
        if (expected_code.size() == 0)
        begin
            report_mismatch("unexpected char", code_mon.out_char, 0);
        end
        else
        begin
            want = expected_code.pop_front();
            if (code_mon.out_char != want.ch)
            begin
                report_mismatch("out_char", code_mon.out_char, want.ch);
            end
            if (code_mon.last_of_item != want.item_end)
            begin
                report_mismatch("last_of_item", code_mon.last_of_item, want.item_end);
            end
            if (code_mon.end_of_code != want.code_end)
            begin
                report_mismatch("end_of_code", code_mon.end_of_code, want.code_end);
            end
        end
        code_beats = code_beats + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_on = 1'b0;
            run_active = 1'b0;
            cur_digit = '0;
            cur_count = '0;
            expected_code.delete();
            mismatches = 0;
            code_beats = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                separator_on = cfg_wdata;
            end
            if (digit_mon.valid && digit_mon.ready)
            begin
                encode_digit(digit_mon.digit_value, digit_mon.end_of_string);
            end
            if (code_mon.valid && code_mon.ready)
            begin
                check_code_beat();
            end
            outstanding <= expected_code.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    // Cycles of quiet after the last expected char
    localparam int DRAIN_CYCLES = 8;
    // Long receiver hold-off: far longer than the 4-entry group queue lasts
    localparam int HOLD_CYCLES = 120;
    // Cycles with no beat at all before the run is called hung
    localparam int STALL_LIMIT = 1000;
    // Digit beats per random phase, four phases
    localparam int PHASE_BEATS = 40;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    // Random idling on both sides while set; cleared for no-gap stretches
    bit idle_on;
    // Ask the receiver for one long hold-off
    bit hold_request;

    int failures;
    int outstanding;
    int quiet_cycles;

    drle_in_if  digit_ch();
    drle_out_if code_ch();

    digit_run_length_encoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .digit_ch  (digit_ch),
        .code_ch   (code_ch)
    );

    drle_code_checker code_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .digit_mon   (digit_ch),
        .code_mon    (code_ch),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // One digit beat: optional gap with valid low, then hold valid until
    // the block takes it. valid stays high afterwards so back-to-back beats
    // never lower and raise it in the same step.
    task automatic send_digit(input logic [3:0] d, input logic eos);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            digit_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        digit_ch.valid <= 1'b1;
        digit_ch.digit_value <= d;
        digit_ch.end_of_string <= eos;
        @(posedge clk);
        while (!digit_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // A run of len equal digits; the last one optionally ends the string
    task automatic send_run(input logic [3:0] d, input int len, input logic eos);
        for (int i = 0; i < len; i++)
        begin
            send_digit(d, eos && (i == len - 1));
        end
    endtask

    // Random string: mostly a few runs of short or medium length, now and
    // then a long run; one string in eight is a lone end-of-string digit.
    // Neighboring runs may share a digit (or map to 9) and merge.
    task automatic send_random_string(inout int sent);
        int runs;
        int len;
        int pick;
        logic [3:0] d;
        if ($urandom_range(0, 7) == 0)
        begin
            send_digit(4'($urandom_range(0, 15)), 1'b1);
            sent = sent + 1;
        end
        else
        begin
            runs = $urandom_range(1, 6);
            for (int r = 0; r < runs; r++)
            begin
                d = 4'($urandom_range(0, 15));
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    len = $urandom_range(1, 3);
                end
                else if (pick < 9)
                begin
                    len = $urandom_range(4, 12);
                end
                else
                begin
                    len = $urandom_range(13, 40);
                end
                send_run(d, len, r == runs - 1);
                sent = sent + len;
            end
        end
    endtask

    // Stop offering digits and wait until every expected char is out,
    // then let the pipeline settle.
    task automatic wait_quiet();
        digit_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_separator(input logic on);
        wait_quiet();
        cfg_we <= 1'b1;
        cfg_wdata <= on;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Receiver: per beat a random stall with ready low when idling is on, or
    // one long hold-off when asked, so that the group queue fills and the block
    // pushes back on digit_ch.
    initial
    begin : code_receiver
        int stall;
        code_ch.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 4) : 0;
            if (hold_request)
            begin
                hold_request = 1'b0;
                code_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall > 0)
            begin
                code_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            code_ch.ready <= 1'b1;
            @(posedge clk);
            while (!code_ch.valid)
            begin
                @(posedge clk);
            end
        end
    end

    // Hang detector: any beat or register write restarts the count
    initial
    begin : watchdog
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((digit_ch.valid && digit_ch.ready) || (code_ch.valid && code_ch.ready)
                || cfg_we || !rst_n)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles = quiet_cycles + 1;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        int sent;
        bit sep_plan [0:3];
        bit idle_plan [0:3];
        sep_plan = '{1'b0, 1'b1, 1'b0, 1'b1};
        idle_plan = '{1'b1, 1'b1, 1'b0, 1'b1};

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        digit_ch.valid = 1'b0;
        digit_ch.digit_value = 4'd0;
        digit_ch.end_of_string = 1'b0;
        idle_on = 1'b1;
        hold_request = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, separator at its reset value (off):
        // single-digit strings with the lowest digit and a digit above nine
        send_run(4'd0, 1, 1'b1);
        send_run(4'd15, 1, 1'b1);

        // Separator on from here
        set_separator(1'b1);
        // 0 0 0 then 9, 12 (taken as 9), 9 ending the string
        send_run(4'd0, 3, 1'b0);
        send_run(4'd9, 1, 1'b0);
        send_run(4'd12, 1, 1'b0);
        send_run(4'd9, 1, 1'b1);
        // run ended by end of string alone
        send_run(4'd5, 2, 1'b1);
        // digit change on the same beat as end of string
        send_run(4'd3, 1, 1'b0);
        send_run(4'd4, 1, 1'b1);
        // two-digit count
        send_run(4'd1, 10, 1'b0);
        send_run(4'd2, 1, 1'b1);

        // Random phases, separator off and on, with and without idling;
        // the long receiver hold-off lands in the second phase.
        for (int p = 0; p < 4; p++)
        begin
            set_separator(sep_plan[p]);
            idle_on = idle_plan[p];
            if (p == 1)
            begin
                hold_request = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_BEATS)
            begin
                send_random_string(sent);
            end
        end

        wait_quiet();
        if (failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/drle_pkg.sv
hw/rtl/drle_if.sv
hw/rtl/drle_queue.sv
hw/rtl/drle_front.sv
hw/rtl/drle_back.sv
hw/rtl/digit_run_length_encoder.sv
dv/drle_code_checker.sv
dv/testbench.sv
